// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication property, checked outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ----- design/bwu_pkg.sv -----
// Package for the breakpoint/watchpoint unit: command codes, defaults, queue entry type.
// Depends on nothing.
package bwu_pkg;
    localparam int BREAK_SLOTS_DEF = 16;
    localparam int WATCH_SLOTS_DEF = 16;

    localparam logic [3:0] CMD_ADD_BRK  = 4'd0;
    localparam logic [3:0] CMD_REM_BRK  = 4'd1;
    localparam logic [3:0] CMD_ADD_RD   = 4'd2;
    localparam logic [3:0] CMD_REM_RD   = 4'd3;
    localparam logic [3:0] CMD_ADD_WR   = 4'd4;
    localparam logic [3:0] CMD_REM_WR   = 4'd5;
    localparam logic [3:0] CMD_CHK_EXEC = 4'd6;
    localparam logic [3:0] CMD_CHK_RD   = 4'd7;
    localparam logic [3:0] CMD_CHK_WR   = 4'd8;
    localparam logic [3:0] CMD_RESUME   = 4'd9;

    // Classified transaction as held in the queue
    typedef struct packed {
        logic [1:0]  tbl;      // 0 break, 1 read, 2 write
        logic        is_add;
        logic        is_rem;
        logic        is_chk;
        logic        is_resume;
        logic [31:0] addr;
        logic [31:0] end_addr;
    } op_t;
endpackage

// ----- design/bwu_front.sv -----
// Front end: accepts a command transaction, decodes it and precomputes the access end.
// Depends on bwu_pkg.
module bwu_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [3:0]    command,
    input  logic [31:0]   address,
    input  logic [2:0]    access_size,
    output logic          q_valid,
    input  logic          q_ready,
    output bwu_pkg::op_t  q_op
);
    bwu_pkg::op_t op_next;
    bwu_pkg::op_t slot_reg [2];
    logic [1:0]   cnt_reg;
    logic         wp_reg, rp_reg;
    logic         push, pop;

    // Decode
    always_comb
    begin
        op_next          = '0;
        op_next.addr     = address;
        op_next.end_addr = address + {29'd0, access_size};
        case (command)
            bwu_pkg::CMD_ADD_BRK:  op_next.is_add = 1'b1;
            bwu_pkg::CMD_REM_BRK:  op_next.is_rem = 1'b1;
            bwu_pkg::CMD_ADD_RD:   begin op_next.is_add = 1'b1; op_next.tbl = 2'd1; end
            bwu_pkg::CMD_REM_RD:   begin op_next.is_rem = 1'b1; op_next.tbl = 2'd1; end
            bwu_pkg::CMD_ADD_WR:   begin op_next.is_add = 1'b1; op_next.tbl = 2'd2; end
            bwu_pkg::CMD_REM_WR:   begin op_next.is_rem = 1'b1; op_next.tbl = 2'd2; end
            bwu_pkg::CMD_CHK_EXEC: op_next.is_chk = 1'b1;
            bwu_pkg::CMD_CHK_RD:   begin op_next.is_chk = 1'b1; op_next.tbl = 2'd1; end
            bwu_pkg::CMD_CHK_WR:   begin op_next.is_chk = 1'b1; op_next.tbl = 2'd2; end
            bwu_pkg::CMD_RESUME:   op_next.is_resume = 1'b1;
            default:               op_next.tbl = 2'd3;
        endcase
    end

    // Two-entry queue
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_op     = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= op_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- design/bwu_back.sv -----
// Back end: the three address tables, counts, paused flag and output register.
// Depends on bwu_pkg.
module bwu_back
#(
    parameter int BREAK_SLOTS = bwu_pkg::BREAK_SLOTS_DEF,
    parameter int WATCH_SLOTS = bwu_pkg::WATCH_SLOTS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  bwu_pkg::op_t  q_op,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          ok,
    output logic          hit,
    output logic [31:0]   hit_address,
    output logic          paused
);
    localparam int BW = $clog2(BREAK_SLOTS + 1);
    localparam int WW = $clog2(WATCH_SLOTS + 1);
    localparam int BI = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
    localparam int WI = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

    logic [31:0]   brk_reg [BREAK_SLOTS];
    logic [31:0]   rd_reg  [WATCH_SLOTS];
    logic [31:0]   wr_reg  [WATCH_SLOTS];
    logic [BW-1:0] bcnt_reg;
    logic [WW-1:0] rcnt_reg, wcnt_reg;
    logic          halt_reg;
    logic          ovalid_reg, ok_reg, hit_reg, paused_reg;
    logic [31:0]   haddr_reg;

    logic          go;
    logic          b_fnd, r_fnd, w_fnd, b_mfnd, r_mfnd, w_mfnd;
    logic [BI-1:0] b_idx;
    logic [WI-1:0] r_idx, w_idx;
    logic [31:0]   b_hv, r_hv, w_hv;
    logic [31:0]   b_last, r_last, w_last;
    logic [BW-1:0] bcnt_m1;
    logic [WW-1:0] rcnt_m1, wcnt_m1;
    logic          ok_next, hit_next;
    logic [31:0]   haddr_next;

    assign q_ready = !ovalid_reg || out_ready;
    assign go      = q_valid && q_ready;
    assign bcnt_m1 = bcnt_reg - BW'(1);
    assign rcnt_m1 = rcnt_reg - WW'(1);
    assign wcnt_m1 = wcnt_reg - WW'(1);
    assign b_last  = brk_reg[bcnt_m1[BI-1:0]];
    assign r_last  = rd_reg[rcnt_m1[WI-1:0]];
    assign w_last  = wr_reg[wcnt_m1[WI-1:0]];

    // Parallel compare across the live entries; first hit in table order
    always_comb
    begin
        b_fnd = 1'b0; b_mfnd = 1'b0; b_idx = '0; b_hv = '0;
        for (int i = BREAK_SLOTS - 1; i >= 0; i--)
        begin
            if (BW'(i) < bcnt_reg && brk_reg[i] == q_op.addr)
            begin
                b_fnd = 1'b1; b_mfnd = 1'b1; b_idx = BI'(i); b_hv = brk_reg[i];
            end
        end
        r_fnd = 1'b0; r_mfnd = 1'b0; r_idx = '0; r_hv = '0;
        w_fnd = 1'b0; w_mfnd = 1'b0; w_idx = '0; w_hv = '0;
        for (int i = WATCH_SLOTS - 1; i >= 0; i--)
        begin
            if (WW'(i) < rcnt_reg)
            begin
                if (rd_reg[i] == q_op.addr)
                begin
                    r_mfnd = 1'b1; r_idx = WI'(i);
                end
                if (rd_reg[i] >= q_op.addr && rd_reg[i] < q_op.end_addr)
                begin
                    r_fnd = 1'b1; r_hv = rd_reg[i];
                end
            end
            if (WW'(i) < wcnt_reg)
            begin
                if (wr_reg[i] == q_op.addr)
                begin
                    w_mfnd = 1'b1; w_idx = WI'(i);
                end
                if (wr_reg[i] >= q_op.addr && wr_reg[i] < q_op.end_addr)
                begin
                    w_fnd = 1'b1; w_hv = wr_reg[i];
                end
            end
        end
    end

    // Result of this transaction
    always_comb
    begin
        ok_next = 1'b0; hit_next = 1'b0; haddr_next = '0;
        if (q_op.is_add)
        begin
            case (q_op.tbl)
                2'd0:    ok_next = b_mfnd || (bcnt_reg < BW'(BREAK_SLOTS));
                2'd1:    ok_next = r_mfnd || (rcnt_reg < WW'(WATCH_SLOTS));
                default: ok_next = w_mfnd || (wcnt_reg < WW'(WATCH_SLOTS));
            endcase
        end
        else if (q_op.is_rem)
        begin
            case (q_op.tbl)
                2'd0:    ok_next = b_mfnd;
                2'd1:    ok_next = r_mfnd;
                default: ok_next = w_mfnd;
            endcase
        end
        else if (q_op.is_chk && !halt_reg)
        begin
            case (q_op.tbl)
                2'd0:    begin hit_next = b_fnd; haddr_next = b_hv; end
                2'd1:    begin hit_next = r_fnd; haddr_next = r_hv; end
                default: begin hit_next = w_fnd; haddr_next = w_hv; end
            endcase
        end
    end

    // Table storage
    always_ff @(posedge clk)
    begin
        if (go && q_op.is_add)
        begin
            if (q_op.tbl == 2'd0 && !b_mfnd && bcnt_reg < BW'(BREAK_SLOTS))
                brk_reg[bcnt_reg[BI-1:0]] <= q_op.addr;
            if (q_op.tbl == 2'd1 && !r_mfnd && rcnt_reg < WW'(WATCH_SLOTS))
                rd_reg[rcnt_reg[WI-1:0]] <= q_op.addr;
            if (q_op.tbl == 2'd2 && !w_mfnd && wcnt_reg < WW'(WATCH_SLOTS))
                wr_reg[wcnt_reg[WI-1:0]] <= q_op.addr;
        end
        if (go && q_op.is_rem)
        begin
            if (q_op.tbl == 2'd0 && b_mfnd) brk_reg[b_idx] <= b_last;
            if (q_op.tbl == 2'd1 && r_mfnd) rd_reg[r_idx] <= r_last;
            if (q_op.tbl == 2'd2 && w_mfnd) wr_reg[w_idx] <= w_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ok_reg     <= ok_next;
            hit_reg    <= hit_next;
            haddr_reg  <= haddr_next;
            paused_reg <= hit_next || (halt_reg && !q_op.is_resume);
        end
    end

    // Counts, paused flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg   <= '0;
            rcnt_reg   <= '0;
            wcnt_reg   <= '0;
            halt_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                ovalid_reg <= 1'b1;
                halt_reg   <= hit_next || (halt_reg && !q_op.is_resume);
                if (q_op.is_add && q_op.tbl == 2'd0 && !b_mfnd && bcnt_reg < BW'(BREAK_SLOTS))
                    bcnt_reg <= bcnt_reg + BW'(1);
                if (q_op.is_add && q_op.tbl == 2'd1 && !r_mfnd && rcnt_reg < WW'(WATCH_SLOTS))
                    rcnt_reg <= rcnt_reg + WW'(1);
                if (q_op.is_add && q_op.tbl == 2'd2 && !w_mfnd && wcnt_reg < WW'(WATCH_SLOTS))
                    wcnt_reg <= wcnt_reg + WW'(1);
                if (q_op.is_rem && q_op.tbl == 2'd0 && b_mfnd) bcnt_reg <= bcnt_m1;
                if (q_op.is_rem && q_op.tbl == 2'd1 && r_mfnd) rcnt_reg <= rcnt_m1;
                if (q_op.is_rem && q_op.tbl == 2'd2 && w_mfnd) wcnt_reg <= wcnt_m1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign ok          = ok_reg;
    assign hit         = hit_reg;
    assign hit_address = haddr_reg;
    assign paused      = paused_reg;
endmodule

// ----- design/breakpoint_watchpoint_unit_core.sv -----
// Channel | handshake            | payload
// in      | in_valid / in_ready  | command, address, access_size
// out     | out_valid / out_ready| ok, hit, hit_address, paused
// One transaction per cycle while the output is not stalled; a result is registered
// in the cycle after the back end takes the queue head, and an input passes the
// slot register of the two-entry queue, then the table compare and its output register.
// Reset clears counts, the internal paused state and the queue; table contents stay undefined.
// A stalled output holds the back end; the queue then fills and drops in_ready.
// Top level of the breakpoint/watchpoint unit; depends on bwu_pkg, bwu_front, bwu_back.
module breakpoint_watchpoint_unit_core
#(
    parameter int BREAK_SLOTS = bwu_pkg::BREAK_SLOTS_DEF,
    parameter int WATCH_SLOTS = bwu_pkg::WATCH_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [31:0] address,
    input  logic [2:0]  access_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic        hit,
    output logic [31:0] hit_address,
    output logic        paused
);
    logic         q_valid, q_ready;
    bwu_pkg::op_t q_op;

    bwu_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .address(address), .access_size(access_size),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    bwu_back #(.BREAK_SLOTS(BREAK_SLOTS), .WATCH_SLOTS(WATCH_SLOTS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .out_valid(out_valid), .out_ready(out_ready), .ok(ok), .hit(hit),
        .hit_address(hit_address), .paused(paused)
    );
endmodule

// ----- design/bwu_checker.sv -----
// Port-level checker for the breakpoint/watchpoint unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bwu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        ok,
    input logic        hit,
    input logic [31:0] hit_address,
    input logic        paused
);
    // A hit always leaves the unit paused
    `CHK_IMPL(a_hit_paused, clk, rst_n, out_valid && hit, paused, "hit without paused")
    // No hit means a zero address
    `CHK_IMPL(a_addr_zero, clk, rst_n, out_valid && !hit, hit_address == 32'd0, "stray hit_address")
    // ok and hit never together
    `CHK_ALWAYS(a_excl, clk, rst_n, !(out_valid && ok && hit), "ok and hit both set")
    // Stalled result stays
    `CHK_IMPL(a_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid, "result dropped")
endmodule

bind breakpoint_watchpoint_unit_core bwu_checker u_bwu_checker
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .hit(hit), .hit_address(hit_address), .paused(paused)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for breakpoint_watchpoint_unit_core: directed table then random
// traffic, each result checked against an in-bench table model. Depends on bwu_pkg and the RTL.
module tb_top;
    localparam int NTAB = 16;
    localparam int N_RANDOM = 750;

    // Table selectors
    localparam int TB_BRK = 0;
    localparam int TB_RD  = 1;
    localparam int TB_WR  = 2;

    typedef struct packed {
        logic        ok;
        logic        hit;
        logic [31:0] hit_address;
        logic        paused;
    } dbg_result_t;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] addr;
        logic [2:0]  size;
        bit          typed;
        dbg_result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  command = '0;
    logic [31:0] address = '0;
    logic [2:0]  access_size = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic        hit;
    logic [31:0] hit_address;
    logic        paused;

    // Shadow state of the unit
    logic [31:0] shadow_tab [3][NTAB];
    int          shadow_cnt [3];
    bit          shadow_paused;

    dbg_result_t expected_q [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    breakpoint_watchpoint_unit_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .address(address), .access_size(access_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .ok(ok), .hit(hit), .hit_address(hit_address), .paused(paused)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predict the result of one command and update the shadow state
    function automatic dbg_result_t predict_debug(input logic [3:0] cmd,
                                                  input logic [31:0] addr,
                                                  input logic [2:0] size);
        dbg_result_t r;
        int t;
        int k;
        bit found;
        logic [31:0] end_addr;
        r = '0;
        found = 1'b0;
        end_addr = addr + 32'(size);
        case (cmd)
            bwu_pkg::CMD_ADD_BRK, bwu_pkg::CMD_ADD_RD, bwu_pkg::CMD_ADD_WR:
            begin
                t = (cmd == bwu_pkg::CMD_ADD_BRK) ? TB_BRK :
                    (cmd == bwu_pkg::CMD_ADD_RD) ? TB_RD : TB_WR;
                for (k = 0; k < shadow_cnt[t]; k++)
                    if (shadow_tab[t][k] == addr) found = 1'b1;
                if (found) r.ok = 1'b1;
                else if (shadow_cnt[t] < NTAB)
                begin
                    shadow_tab[t][shadow_cnt[t]] = addr;
                    shadow_cnt[t]++;
                    r.ok = 1'b1;
                end
            end
            bwu_pkg::CMD_REM_BRK, bwu_pkg::CMD_REM_RD, bwu_pkg::CMD_REM_WR:
            begin
                t = (cmd == bwu_pkg::CMD_REM_BRK) ? TB_BRK :
                    (cmd == bwu_pkg::CMD_REM_RD) ? TB_RD : TB_WR;
                for (k = 0; k < shadow_cnt[t] && !found; k++)
                    if (shadow_tab[t][k] == addr)
                    begin
                        found = 1'b1;
                        shadow_cnt[t]--;
                        shadow_tab[t][k] = shadow_tab[t][shadow_cnt[t]];
                    end
                r.ok = found;
            end
            bwu_pkg::CMD_CHK_EXEC:
                if (!shadow_paused)
                    for (k = 0; k < shadow_cnt[TB_BRK] && !r.hit; k++)
                        if (shadow_tab[TB_BRK][k] == addr)
                        begin
                            r.hit = 1'b1;
                            r.hit_address = addr;
                        end
            bwu_pkg::CMD_CHK_RD, bwu_pkg::CMD_CHK_WR:
            begin
                t = (cmd == bwu_pkg::CMD_CHK_RD) ? TB_RD : TB_WR;
                if (!shadow_paused)
                    for (k = 0; k < shadow_cnt[t] && !r.hit; k++)
                        if (shadow_tab[t][k] >= addr && shadow_tab[t][k] < end_addr)
                        begin
                            r.hit = 1'b1;
                            r.hit_address = shadow_tab[t][k];
                        end
            end
            bwu_pkg::CMD_RESUME: shadow_paused = 1'b0;
            default: ;
        endcase
        if (r.hit) shadow_paused = 1'b1;
        r.paused = shadow_paused;
        return r;
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_cmd(input logic [3:0] cmd, input logic [31:0] addr,
                            input logic [2:0] size, input bit typed, input dbg_result_t res);
        dbg_result_t p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        access_size <= size;
        p = predict_debug(cmd, addr, size);
        if (typed && p != res)
        begin
            $error("directed row cmd %0d: table %h predictor %h", cmd, res, p);
            fail_count++;
        end
        expected_q.push_back(p);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Release the input and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
    endtask

    // Random pick of a watch/break address biased to hit existing entries
    function automatic logic [31:0] pick_addr(input int t);
        int sel;
        sel = $urandom_range(9);
        if (shadow_cnt[t] > 0 && sel < 5)
            return shadow_tab[t][$urandom_range(shadow_cnt[t] - 1)] - 32'($urandom_range(sel));
        if (sel < 7) return 32'h1000 + 32'($urandom_range(63));
        if (sel == 7) return 32'hFFFF_FFFF - 32'($urandom_range(5));
        return $urandom;
    endfunction

    // Receiver: random stalls and checking
    always @(posedge clk)
    begin
        dbg_result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (ok !== e.ok)
                    begin
                        $error("ok: expected %0d actual %0d", e.ok, ok); fail_count++;
                    end
                    if (hit !== e.hit)
                    begin
                        $error("hit: expected %0d actual %0d", e.hit, hit); fail_count++;
                    end
                    if (hit_address !== e.hit_address)
                    begin
                        $error("hit_address: expected %h actual %h", e.hit_address,
                               hit_address);
                        fail_count++;
                    end
                    if (paused !== e.paused)
                    begin
                        $error("paused: expected %0d actual %0d", e.paused, paused);
                        fail_count++;
                    end
                end
            end
            out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        int n;
        int i;
        int t;
        int sel;
        logic [3:0] c;
        shadow_cnt = '{0, 0, 0};
        shadow_paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: typed where obvious
        rows = '{
            '{bwu_pkg::CMD_CHK_EXEC, 32'h0, 3'd1, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_REM_BRK, 32'h0, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_ADD_BRK, 32'h0, 3'd7, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_ADD_BRK, 32'hFFFF_FFFF, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_ADD_BRK, 32'h0, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_CHK_EXEC, 32'hFFFF_FFFF, 3'd0, 1'b1,
              '{1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1}},
            '{bwu_pkg::CMD_CHK_EXEC, 32'h0, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b1}},
            '{bwu_pkg::CMD_ADD_RD, 32'hFFFF_FFFF, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b1}},
            '{bwu_pkg::CMD_RESUME, 32'h0, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_RESUME, 32'h0, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_CHK_RD, 32'hFFFF_FFFE, 3'd4, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_CHK_RD, 32'hFFFF_FFFC, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_CHK_RD, 32'hFFFF_FFFA, 3'd7, 1'b0, '0},
            '{bwu_pkg::CMD_ADD_WR, 32'h0000_1003, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_ADD_WR, 32'h0000_1001, 3'd0, 1'b0, '0},
            '{4'd15, 32'hFFFF_FFFF, 3'd7, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}},
            '{bwu_pkg::CMD_RESUME, 32'h0, 3'd0, 1'b0, '0},
            '{bwu_pkg::CMD_CHK_WR, 32'h0000_1000, 3'd4, 1'b0, '0},
            '{bwu_pkg::CMD_REM_WR, 32'h0000_1003, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b1}},
            '{bwu_pkg::CMD_REM_RD, 32'hFFFF_FFFF, 3'd0, 1'b1, '{1'b1, 1'b0, 32'h0, 1'b1}},
            '{4'd10, 32'h5555_AAAA, 3'd5, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b1}},
            '{bwu_pkg::CMD_RESUME, 32'h0, 3'd0, 1'b1, '{1'b0, 1'b0, 32'h0, 1'b0}}
        };
        foreach (rows[k])
        begin
            row = rows[k];
            send_cmd(row.cmd, row.addr, row.size, row.typed, row.res);
        end
        // Fill the break table past full, then confirm the full case fails
        for (i = 0; i < 17; i++)
            send_cmd(bwu_pkg::CMD_ADD_BRK, 32'h8000_0000 + 32'(i), 3'd0, 1'b0, '0);
        send_cmd(bwu_pkg::CMD_ADD_BRK, 32'hAAAA_5555, 3'd0, 1'b1,
                 '{1'b0, 1'b0, 32'h0, 1'b0});

        // Let everything drain before random traffic
        drain();

        // Random phases
        for (n = 0; n < N_RANDOM; n++)
        begin
            case (n * 5 / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (n == N_RANDOM / 2)
                drain();
            sel = $urandom_range(99);
            if (sel < 2) c = 4'(10 + $urandom_range(5));
            else if (sel < 30) c = 4'($urandom_range(bwu_pkg::CMD_REM_WR));
            else if (sel < 85) c = 4'(bwu_pkg::CMD_CHK_EXEC + $urandom_range(2));
            else c = bwu_pkg::CMD_RESUME;
            t = (c == bwu_pkg::CMD_CHK_EXEC) ? TB_BRK :
                (c == bwu_pkg::CMD_CHK_RD) ? TB_RD :
                (c == bwu_pkg::CMD_CHK_WR) ? TB_WR :
                (c <= bwu_pkg::CMD_REM_WR) ? int'(c) / 2 : TB_BRK;
            send_cmd(c, pick_addr(t), 3'($urandom_range(7)), 1'b0, '0);
        end
        recv_stall_pct = 0;
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("breakpoint_watchpoint_unit_core verification clean");
        else
            $display("breakpoint_watchpoint_unit_core verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("breakpoint_watchpoint_unit_core verification failed");
        $finish;
    end
endmodule
